>>> rtl/core/vna_pkg.sv
// Shared types and codes for the vertex normal accumulator.
package vna_pkg;

    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_FACE  = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_ZERO    = 2'd2;

    localparam logic [1:0] CFG_SCALE  = 2'd0;
    localparam logic [1:0] CFG_SMOOTH = 2'd1;
    localparam logic [1:0] CFG_COUNT  = 2'd2;

    typedef logic signed [32:0] opnd_t;
    typedef logic signed [65:0] prod_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } pos_t;

    typedef struct packed {
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] z;
    } nrm_t;

    typedef struct packed {
        logic               zero;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } norm_res_t;

endpackage

>>> rtl/core/vna_mul.sv
// Sequential 33x33 signed multiplier, one 18x18 partial product per cycle.
module vna_mul
    import vna_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  opnd_t a,
    input  opnd_t b,
    output logic  done,
    output prod_t p
);

    logic [1:0]         step_reg;
    logic               busy_reg;
    logic               done_reg;
    opnd_t              a_reg;
    opnd_t              b_reg;
    prod_t              acc_reg;
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic signed [35:0] pp;
    logic [5:0]         sh;
    prod_t              term;

    always_comb
    begin
        unique case (step_reg)
            2'd0:
            begin
                x  = {1'b0, a_reg[16:0]};
                y  = {1'b0, b_reg[16:0]};
                sh = 6'd0;
            end
            2'd1:
            begin
                x  = {1'b0, a_reg[16:0]};
                y  = {{2{b_reg[32]}}, b_reg[32:17]};
                sh = 6'd17;
            end
            2'd2:
            begin
                x  = {{2{a_reg[32]}}, a_reg[32:17]};
                y  = {1'b0, b_reg[16:0]};
                sh = 6'd17;
            end
            default:
            begin
                x  = {{2{a_reg[32]}}, a_reg[32:17]};
                y  = {{2{b_reg[32]}}, b_reg[32:17]};
                sh = 6'd34;
            end
        endcase
        pp   = x * y;
        term = prod_t'(pp) <<< sh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 2'd1;
            if (step_reg == 2'd3)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_reg + term;
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

>>> rtl/core/vna_norm.sv
// Normal vector scaling to unit length: shift search, squares, square root, divides.
module vna_norm
    import vna_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  nrm_t      vec,
    output logic      done,
    output norm_res_t res
);

    localparam logic [2:0] N_IDLE  = 3'd0;
    localparam logic [2:0] N_MAG   = 3'd1;
    localparam logic [2:0] N_SHIFT = 3'd2;
    localparam logic [2:0] N_SQ    = 3'd3;
    localparam logic [2:0] N_SQRT  = 3'd4;
    localparam logic [2:0] N_DIVI  = 3'd5;
    localparam logic [2:0] N_DIVS  = 3'd6;
    localparam logic [2:0] N_FIN   = 3'd7;

    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    logic [4:0]         cnt_reg;
    logic [1:0]         k_reg;
    nrm_t               v_reg;
    logic [63:0]        m_reg [3];
    logic [2:0]         neg_reg;
    logic [61:0]        sq_reg;
    logic [63:0]        sum_reg;
    logic [63:0]        x_reg;
    logic [63:0]        root_reg;
    logic [63:0]        bit_reg;
    logic [32:0]        len_reg;
    logic [33:0]        rem_reg;
    logic [15:0]        num_reg;
    logic [15:0]        q_reg;
    logic               zero_reg;
    logic signed [15:0] rx_reg;
    logic signed [15:0] ry_reg;
    logic signed [15:0] rz_reg;

    logic               all_zero;
    logic               too_big;
    logic [30:0]        r_sel;
    logic               neg_sel;
    logic [63:0]        trial_root;
    logic [46:0]        num_full;
    logic [33:0]        trial;
    logic               ge;
    logic [15:0]        q_new;
    logic [15:0]        q_cap;
    logic signed [15:0] q_signed;

    assign all_zero = (m_reg[0] == '0) && (m_reg[1] == '0) && (m_reg[2] == '0);
    assign too_big  = (m_reg[0][63:31] != '0) || (m_reg[1][63:31] != '0)
                   || (m_reg[2][63:31] != '0);

    always_comb
    begin
        unique case (k_reg)
            2'd0:
            begin
                r_sel   = m_reg[0][30:0];
                neg_sel = neg_reg[0];
            end
            2'd1:
            begin
                r_sel   = m_reg[1][30:0];
                neg_sel = neg_reg[1];
            end
            default:
            begin
                r_sel   = m_reg[2][30:0];
                neg_sel = neg_reg[2];
            end
        endcase
    end

    // root stays put through the divides, so the rounding term comes from it directly
    assign trial_root = root_reg + bit_reg;
    assign num_full   = 47'({r_sel, 15'd0}) + 47'(root_reg[32:1]);
    assign trial      = {rem_reg[32:0], num_reg[15]};
    assign ge         = trial >= {1'b0, len_reg};
    assign q_new      = {q_reg[14:0], ge};
    assign q_cap      = q_new[15] ? 16'h7FFF : q_new;
    assign q_signed   = neg_sel ? -$signed(q_cap) : $signed(q_cap);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            N_IDLE:  if (start) state_next = N_MAG;
            N_MAG:   state_next = N_SHIFT;
            N_SHIFT:
            begin
                if (all_zero)
                    state_next = N_FIN;
                else if (!too_big)
                    state_next = N_SQ;
            end
            N_SQ:    if (k_reg == 2'd3) state_next = N_SQRT;
            N_SQRT:  if (cnt_reg == 5'd31) state_next = N_DIVI;
            N_DIVI:  state_next = N_DIVS;
            N_DIVS:
            begin
                if (cnt_reg == 5'd15)
                    state_next = (k_reg == 2'd2) ? N_FIN : N_DIVI;
            end
            default: state_next = N_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= N_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    v_reg    <= vec;
                    zero_reg <= 1'b0;
                    rx_reg   <= '0;
                    ry_reg   <= '0;
                    rz_reg   <= '0;
                end
            end
            N_MAG:
            begin
                m_reg[0] <= v_reg.x[63] ? 64'(-v_reg.x) : 64'(v_reg.x);
                m_reg[1] <= v_reg.y[63] ? 64'(-v_reg.y) : 64'(v_reg.y);
                m_reg[2] <= v_reg.z[63] ? 64'(-v_reg.z) : 64'(v_reg.z);
                neg_reg  <= {v_reg.z[63], v_reg.y[63], v_reg.x[63]};
            end
            N_SHIFT:
            begin
                if (all_zero)
                    zero_reg <= 1'b1;
                else if (too_big)
                begin
                    m_reg[0] <= m_reg[0] >> 1;
                    m_reg[1] <= m_reg[1] >> 1;
                    m_reg[2] <= m_reg[2] >> 1;
                end
                k_reg   <= 2'd0;
                sq_reg  <= '0;
                sum_reg <= '0;
            end
            N_SQ:
            begin
                sq_reg  <= r_sel * r_sel;
                sum_reg <= sum_reg + 64'(sq_reg);
                k_reg   <= k_reg + 2'd1;
                if (k_reg == 2'd3)
                begin
                    x_reg    <= sum_reg + 64'(sq_reg);
                    root_reg <= '0;
                    bit_reg  <= 64'd1 << 62;
                    cnt_reg  <= '0;
                end
            end
            N_SQRT:
            begin
                if (x_reg >= trial_root)
                begin
                    x_reg    <= x_reg - trial_root;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg + 5'd1;
                k_reg   <= 2'd0;
            end
            N_DIVI:
            begin
                if (k_reg == 2'd0)
                    len_reg <= root_reg[32:0];
                rem_reg <= 34'(num_full[46:16]);
                num_reg <= num_full[15:0];
                q_reg   <= '0;
                cnt_reg <= '0;
            end
            N_DIVS:
            begin
                rem_reg <= ge ? trial - {1'b0, len_reg} : trial;
                num_reg <= {num_reg[14:0], 1'b0};
                q_reg   <= q_new;
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd15)
                begin
                    unique case (k_reg)
                        2'd0:    rx_reg <= q_signed;
                        2'd1:    ry_reg <= q_signed;
                        default: rz_reg <= q_signed;
                    endcase
                    k_reg <= k_reg + 2'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign done     = (state_reg == N_FIN);
    assign res.zero = zero_reg;
    assign res.x    = rx_reg;
    assign res.y    = ry_reg;
    assign res.z    = rz_reg;

endmodule

>>> rtl/core/vertex_normal_accumulator.sv
// Vertex normal accumulator top level: control, position and normal memories.
// Faces take longer with position smoothing, which sweeps each corner over every entry
//   below the vertex count; a read of a zero normal skips the square root and divides.
// Throughput: one word at a time; faces are bound by the shared 18x18 multiplier
//   (two products per cross-product component) and the normal memory RMW.
// Reset: registers take their defaults, then the normal memory is cleared entry by
//   entry with in_ready low; the position memory is not cleared.
module vertex_normal_accumulator
    import vna_pkg::*;
#(
    parameter int MAX_VERTICES = 4096
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         func,
    input  logic [11:0]        vertex_index,
    input  logic [11:0]        corner_b,
    input  logic [11:0]        corner_c,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic signed [31:0] coord_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic signed [15:0] normal_x,
    output logic signed [15:0] normal_y,
    output logic signed [15:0] normal_z,
    output logic               saturated
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int LW = 17;
    localparam logic [LW-1:0] MAXV     = LW'(MAX_VERTICES);
    localparam logic [AW-1:0] CLR_LAST = AW'(MAX_VERTICES - 1);

    localparam logic [4:0] S_CLEAR  = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_LD_MUL = 5'd2;
    localparam logic [4:0] S_LD_WR  = 5'd3;
    localparam logic [4:0] S_F_A    = 5'd4;
    localparam logic [4:0] S_F_B    = 5'd5;
    localparam logic [4:0] S_F_C    = 5'd6;
    localparam logic [4:0] S_F_D    = 5'd7;
    localparam logic [4:0] S_F_UV   = 5'd8;
    localparam logic [4:0] S_F_MS   = 5'd9;
    localparam logic [4:0] S_F_MW   = 5'd10;
    localparam logic [4:0] S_C_INIT = 5'd11;
    localparam logic [4:0] S_C_RD   = 5'd12;
    localparam logic [4:0] S_C_WR   = 5'd13;
    localparam logic [4:0] S_R_RD   = 5'd14;
    localparam logic [4:0] S_R_WT   = 5'd15;
    localparam logic [4:0] S_R_NW   = 5'd16;
    localparam logic [4:0] S_DONE   = 5'd17;

    function automatic logic [AW-1:0] to_addr(input logic [11:0] i);
        logic [LW-1:0] e;
        e = LW'(i);
        return e[AW-1:0];
    endfunction

    function automatic logic [32:0] sat_q16(input logic signed [49:0] p);
        logic signed [41:0] s;
        s = p[49:8];
        if (s[41:31] == {11{s[31]}})
            return {1'b0, s[31:0]};
        return {1'b1, s[41] ? 32'h8000_0000 : 32'h7FFF_FFFF};
    endfunction

    function automatic logic [64:0] sat_add(input logic signed [63:0] a,
                                            input logic signed [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return {1'b1, s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF};
        return {1'b0, s[63:0]};
    endfunction

    logic [4:0]         state_reg;
    logic [4:0]         state_next;
    logic [15:0]        scale_reg;
    logic               smooth_reg;
    logic [12:0]        count_reg;
    logic [AW-1:0]      clr_cnt_reg;
    logic               out_valid_reg;

    logic [AW-1:0]      ca_reg;
    logic [AW-1:0]      cb_reg;
    logic [AW-1:0]      cc_reg;
    logic signed [31:0] cx_reg;
    logic signed [31:0] cy_reg;
    logic signed [31:0] cz_reg;
    logic [1:0]         st_reg;
    logic               sat_reg;
    logic signed [15:0] rx_reg;
    logic signed [15:0] ry_reg;
    logic signed [15:0] rz_reg;
    logic signed [49:0] ldx_reg;
    logic signed [49:0] ldy_reg;
    logic signed [49:0] ldz_reg;
    pos_t               pa_reg;
    pos_t               pb_reg;
    pos_t               pc_reg;
    opnd_t              u_reg [3];
    opnd_t              v_reg [3];
    logic [2:0]         pidx_reg;
    prod_t              prod_reg;
    logic signed [63:0] n_reg [3];
    logic [1:0]         k_reg;
    logic [AW-1:0]      j_reg;

    logic [1:0]         status_reg;
    logic signed [15:0] nx_out_reg;
    logic signed [15:0] ny_out_reg;
    logic signed [15:0] nz_out_reg;
    logic               sat_out_reg;

    pos_t               pos_mem [MAX_VERTICES];
    nrm_t               nrm_mem [MAX_VERTICES];
    pos_t               pos_rdata;
    nrm_t               nrm_rdata;
    logic [AW-1:0]      pos_raddr;
    logic [AW-1:0]      nrm_raddr;
    logic               pos_we;
    pos_t               pos_wdata;
    logic               nrm_we;
    logic [AW-1:0]      nrm_waddr;
    nrm_t               nrm_wdata;

    logic [LW-1:0]      limit;
    logic               ok_a;
    logic               ok_b;
    logic               ok_c;
    logic [32:0]        sx;
    logic [32:0]        sy;
    logic [32:0]        sz;
    opnd_t              mul_a;
    opnd_t              mul_b;
    logic               mul_start;
    logic               mul_done;
    prod_t              mul_p;
    logic signed [66:0] diff;
    pos_t               key;
    logic [AW-1:0]      corner_addr;
    logic               match;
    logic               sweep_end;
    logic [64:0]        addx;
    logic [64:0]        addy;
    logic [64:0]        addz;
    logic               norm_start;
    logic               norm_done;
    norm_res_t          norm_res;
    logic               out_load;

    assign limit = (LW'(count_reg) > MAXV) ? MAXV : LW'(count_reg);
    assign ok_a  = LW'(vertex_index) < limit;
    assign ok_b  = LW'(corner_b) < limit;
    assign ok_c  = LW'(corner_c) < limit;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // load path: file (x, y, z) is stored as (x, z, -y)
    assign sx = sat_q16(ldx_reg);
    assign sy = sat_q16(ldz_reg);
    assign sz = sat_q16(ldy_reg);
    assign pos_we    = (state_reg == S_LD_WR);
    assign pos_wdata = '{x: sx[31:0], y: sy[31:0], z: sz[31:0]};

    always_comb
    begin
        unique case (state_reg)
            S_F_A:   pos_raddr = ca_reg;
            S_F_B:   pos_raddr = cb_reg;
            S_F_C:   pos_raddr = cc_reg;
            default: pos_raddr = j_reg;
        endcase
    end

    assign nrm_raddr = (state_reg == S_R_RD) ? ca_reg : j_reg;

    always_ff @(posedge clk)
    begin
        if (pos_we)
            pos_mem[ca_reg] <= pos_wdata;
        pos_rdata <= pos_mem[pos_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (nrm_we)
            nrm_mem[nrm_waddr] <= nrm_wdata;
        nrm_rdata <= nrm_mem[nrm_raddr];
    end

    // cross product terms, two products per component
    always_comb
    begin
        unique case (pidx_reg)
            3'd0:
            begin
                mul_a = u_reg[1];
                mul_b = v_reg[2];
            end
            3'd1:
            begin
                mul_a = u_reg[2];
                mul_b = v_reg[1];
            end
            3'd2:
            begin
                mul_a = u_reg[2];
                mul_b = v_reg[0];
            end
            3'd3:
            begin
                mul_a = u_reg[0];
                mul_b = v_reg[2];
            end
            3'd4:
            begin
                mul_a = u_reg[0];
                mul_b = v_reg[1];
            end
            default:
            begin
                mul_a = u_reg[1];
                mul_b = v_reg[0];
            end
        endcase
    end

    assign mul_start = (state_reg == S_F_MS);
    assign diff      = 67'(prod_reg) - 67'(mul_p);

    vna_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    always_comb
    begin
        unique case (k_reg)
            2'd0:
            begin
                key         = pa_reg;
                corner_addr = ca_reg;
            end
            2'd1:
            begin
                key         = pb_reg;
                corner_addr = cb_reg;
            end
            default:
            begin
                key         = pc_reg;
                corner_addr = cc_reg;
            end
        endcase
    end

    assign match     = !smooth_reg || (pos_rdata == key);
    assign sweep_end = !smooth_reg || ((LW'(j_reg) + LW'(1)) == limit);
    assign addx      = sat_add(nrm_rdata.x, n_reg[0]);
    assign addy      = sat_add(nrm_rdata.y, n_reg[1]);
    assign addz      = sat_add(nrm_rdata.z, n_reg[2]);

    assign nrm_we    = (state_reg == S_CLEAR) || ((state_reg == S_C_WR) && match);
    assign nrm_waddr = (state_reg == S_CLEAR) ? clr_cnt_reg : j_reg;
    assign nrm_wdata = (state_reg == S_CLEAR) ? '0
                     : '{x: addx[63:0], y: addy[63:0], z: addz[63:0]};

    assign norm_start = (state_reg == S_R_WT);

    vna_norm u_norm
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (norm_start),
        .vec   (nrm_rdata),
        .done  (norm_done),
        .res   (norm_res)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (clr_cnt_reg == CLR_LAST) state_next = S_IDLE;
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (func)
                        FUNC_LOAD: state_next = ok_a ? S_LD_MUL : S_DONE;
                        FUNC_FACE: state_next = (ok_a && ok_b && ok_c) ? S_F_A : S_DONE;
                        FUNC_READ: state_next = ok_a ? S_R_RD : S_DONE;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_LD_MUL: state_next = S_LD_WR;
            S_LD_WR:  state_next = S_DONE;
            S_F_A:    state_next = S_F_B;
            S_F_B:    state_next = S_F_C;
            S_F_C:    state_next = S_F_D;
            S_F_D:    state_next = S_F_UV;
            S_F_UV:   state_next = S_F_MS;
            S_F_MS:   state_next = S_F_MW;
            S_F_MW:
            begin
                if (mul_done)
                    state_next = (pidx_reg == 3'd5) ? S_C_INIT : S_F_MS;
            end
            S_C_INIT: state_next = S_C_RD;
            S_C_RD:   state_next = S_C_WR;
            S_C_WR:
            begin
                if (!sweep_end)
                    state_next = S_C_RD;
                else
                    state_next = (k_reg == 2'd2) ? S_DONE : S_C_INIT;
            end
            S_R_RD:   state_next = S_R_WT;
            S_R_WT:   state_next = S_R_NW;
            S_R_NW:   if (norm_done) state_next = S_DONE;
            S_DONE:   if (out_load) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            scale_reg     <= 16'd256;
            smooth_reg    <= 1'b0;
            count_reg     <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_SCALE:  scale_reg  <= cfg_data;
                    CFG_SMOOTH: smooth_reg <= cfg_data[0];
                    CFG_COUNT:  count_reg  <= cfg_data[12:0];
                    default:
                    begin
                    end
                endcase
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ca_reg   <= to_addr(vertex_index);
                    cb_reg   <= to_addr(corner_b);
                    cc_reg   <= to_addr(corner_c);
                    cx_reg   <= coord_x;
                    cy_reg   <= coord_y;
                    cz_reg   <= coord_z;
                    sat_reg  <= 1'b0;
                    rx_reg   <= '0;
                    ry_reg   <= '0;
                    rz_reg   <= '0;
                    pidx_reg <= '0;
                    k_reg    <= '0;
                    unique case (func)
                        FUNC_LOAD: st_reg <= ok_a ? ST_OK : ST_RANGE;
                        FUNC_FACE: st_reg <= (ok_a && ok_b && ok_c) ? ST_OK : ST_RANGE;
                        FUNC_READ: st_reg <= ok_a ? ST_OK : ST_RANGE;
                        default:   st_reg <= ST_OK;
                    endcase
                end
            end
            S_LD_MUL:
            begin
                ldx_reg <= $signed({cx_reg[31], cx_reg}) * $signed({1'b0, scale_reg});
                ldy_reg <= (-$signed({cy_reg[31], cy_reg})) * $signed({1'b0, scale_reg});
                ldz_reg <= $signed({cz_reg[31], cz_reg}) * $signed({1'b0, scale_reg});
            end
            S_LD_WR:
            begin
                sat_reg <= sx[32] | sy[32] | sz[32];
            end
            S_F_B:    pa_reg <= pos_rdata;
            S_F_C:    pb_reg <= pos_rdata;
            S_F_D:    pc_reg <= pos_rdata;
            S_F_UV:
            begin
                u_reg[0] <= opnd_t'(pb_reg.x) - opnd_t'(pc_reg.x);
                u_reg[1] <= opnd_t'(pb_reg.y) - opnd_t'(pc_reg.y);
                u_reg[2] <= opnd_t'(pb_reg.z) - opnd_t'(pc_reg.z);
                v_reg[0] <= opnd_t'(pb_reg.x) - opnd_t'(pa_reg.x);
                v_reg[1] <= opnd_t'(pb_reg.y) - opnd_t'(pa_reg.y);
                v_reg[2] <= opnd_t'(pb_reg.z) - opnd_t'(pa_reg.z);
            end
            S_F_MW:
            begin
                if (mul_done)
                begin
                    if (!pidx_reg[0])
                        prod_reg <= mul_p;
                    else
                    begin
                        unique case (pidx_reg[2:1])
                            2'd0:    n_reg[0] <= {{13{diff[66]}}, diff[66:16]};
                            2'd1:    n_reg[1] <= {{13{diff[66]}}, diff[66:16]};
                            default: n_reg[2] <= {{13{diff[66]}}, diff[66:16]};
                        endcase
                    end
                    pidx_reg <= pidx_reg + 3'd1;
                end
            end
            S_C_INIT: j_reg <= smooth_reg ? '0 : corner_addr;
            S_C_WR:
            begin
                if (match && (addx[64] || addy[64] || addz[64]))
                    sat_reg <= 1'b1;
                if (!sweep_end)
                    j_reg <= j_reg + AW'(1);
                else
                    k_reg <= k_reg + 2'd1;
            end
            S_R_NW:
            begin
                if (norm_done)
                begin
                    st_reg <= norm_res.zero ? ST_ZERO : ST_OK;
                    rx_reg <= norm_res.x;
                    ry_reg <= norm_res.y;
                    rz_reg <= norm_res.z;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg  <= st_reg;
            nx_out_reg  <= rx_reg;
            ny_out_reg  <= ry_reg;
            nz_out_reg  <= rz_reg;
            sat_out_reg <= sat_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign normal_x  = nx_out_reg;
    assign normal_y  = ny_out_reg;
    assign normal_z  = nz_out_reg;
    assign saturated = sat_out_reg;

    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !in_ready)
        else $error("word accepted during normal memory clear");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != S_IDLE))
        else $error("accepted word did not start work");

    a_nrm_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        nrm_we |-> (state_reg == S_CLEAR || state_reg == S_C_WR))
        else $error("normal memory written outside clear or corner update");

    a_done_to_output: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !out_valid_reg) |=> out_valid_reg)
        else $error("finished word not presented");

endmodule
